[rtl/core/periodic_task_slot_scheduler_macros.svh]
// assertion macros for the periodic task slot scheduler
`ifndef PERIODIC_TASK_SLOT_SCHEDULER_MACROS_SVH
`define PERIODIC_TASK_SLOT_SCHEDULER_MACROS_SVH

// same-cycle implication, checked out of reset
`define PTSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// next-cycle implication, checked out of reset
`define PTSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

[rtl/core/ptss_pkg.sv]
// shared constants, codes and types of the periodic task slot scheduler
package ptss_pkg;

    // slot table size and derived widths
    localparam int NUM_SLOTS   = 8;
    localparam int SLOT_IW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MAX_RESULTS = 8;
    localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);

    // field widths
    localparam int ACT_W  = 2;
    localparam int SLOT_W = 3;
    localparam int TASK_W = 16;
    localparam int CNT_W  = 16;
    localparam int TPS_W  = 8;

    // reset value of the ticks_per_step register
    localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1);

    // command codes
    typedef enum logic [ACT_W-1:0] {
        ACT_TICK    = 2'd0,
        ACT_CREATE  = 2'd1,
        ACT_DELETE  = 2'd2,
        ACT_SET_RUN = 2'd3
    } t_action;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    // one slot record as it moves around the ring
    typedef struct packed {
        logic              valid;
        logic              run;
        logic [TASK_W-1:0] task_id;
        logic [CNT_W-1:0]  cnt;
        logic [CNT_W-1:0]  period;
    } t_slot_rec;

    // per-cell control
    typedef struct packed {
        logic shift;
        logic create;
        logic set_run;
        logic del;
    } t_cell_cmd;

endpackage

[rtl/core/ptss_cell.sv]
// one slot cell of the rotating slot ring
module ptss_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ptss_pkg::t_cell_cmd           i_cmd,
    input  ptss_pkg::t_slot_rec           i_rec_in,
    input  logic [ptss_pkg::TASK_W-1:0]   i_task_id,
    input  logic [ptss_pkg::CNT_W-1:0]    i_first_delay,
    input  logic [ptss_pkg::CNT_W-1:0]    i_period,
    input  logic                          i_running,
    output ptss_pkg::t_slot_rec           o_rec
);

    logic                        r_valid;
    logic                        r_run;
    logic [ptss_pkg::TASK_W-1:0] r_task;
    logic [ptss_pkg::CNT_W-1:0]  r_cnt;
    logic [ptss_pkg::CNT_W-1:0]  r_period;

    // valid mark: shift, create, delete on identifier match
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.shift) begin
            r_valid <= i_rec_in.valid;
        end else if (i_cmd.create) begin
            r_valid <= 1'b1;
        end else if (i_cmd.del && r_valid && (r_task == i_task_id)) begin
            r_valid <= 1'b0;
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_run    <= i_rec_in.run;
            r_task   <= i_rec_in.task_id;
            r_cnt    <= i_rec_in.cnt;
            r_period <= i_rec_in.period;
        end else if (i_cmd.create) begin
            r_run    <= i_running;
            r_task   <= i_task_id;
            r_cnt    <= i_first_delay;
            r_period <= i_period;
        end else if (i_cmd.set_run) begin
            r_run    <= i_running;
        end
    end

    assign o_rec = '{valid: r_valid, run: r_run, task_id: r_task, cnt: r_cnt, period: r_period};

endmodule

[rtl/core/ptss_update.sv]
// countdown and reload of the slot record leaving the head of the ring
module ptss_update (
    input  ptss_pkg::t_slot_rec i_rec,
    output ptss_pkg::t_slot_rec o_rec,
    output logic                o_fire
);

    logic active;

    assign active = i_rec.valid && i_rec.run;
    assign o_fire = active && (i_rec.cnt == '0);

    // reload on fire (period zero wraps to all ones), else count down while valid and running
    always_comb begin
        o_rec = i_rec;
        if (o_fire) begin
            o_rec.cnt = i_rec.period - ptss_pkg::CNT_W'(1);
        end else if (active) begin
            o_rec.cnt = i_rec.cnt - ptss_pkg::CNT_W'(1);
        end
    end

endmodule

[rtl/core/periodic_task_slot_scheduler.sv]
// top level of the periodic task slot scheduler: ring of slot cells and step sequencer
//
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+----------------------------------
//  command   | in        | start high, busy low        | action slot task_id first_delay
//            |           |                             | period running
//  fire      | out       | o_fire_strobe, one cycle    | fired_slot fired_task last
//  config    | in        | i_cfg_we                    | ticks_per_step
//
// create, delete, set running and a tick that does not end a step leave busy low;
// a tick that ends a step keeps busy high while the ring rotates once through the
// countdown unit, slot by slot, and then while the held result is flushed.
// a fire result is held until the next firing slot or the flush, then leaves in the cycle after,
// so the final one of a step shows in the first cycle after busy falls.
// synchronous active-low reset empties every slot, zeroes the prescaler and sets
// ticks_per_step to 1; results cannot be stalled.
module periodic_task_slot_scheduler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ptss_pkg::ACT_W-1:0]    i_action,
    input  logic [ptss_pkg::SLOT_W-1:0]   i_slot,
    input  logic [ptss_pkg::TASK_W-1:0]   i_task_id,
    input  logic [ptss_pkg::CNT_W-1:0]    i_first_delay,
    input  logic [ptss_pkg::CNT_W-1:0]    i_period,
    input  logic                          i_running,
    input  logic                          i_cfg_we,
    input  logic [ptss_pkg::TPS_W-1:0]    i_cfg_wdata,
    output logic                          o_fire_strobe,
    output logic [ptss_pkg::SLOT_W-1:0]   o_fired_slot,
    output logic [ptss_pkg::TASK_W-1:0]   o_fired_task,
    output logic                          o_last
);

    localparam int N = ptss_pkg::NUM_SLOTS;

    ptss_pkg::t_state                 r_state, n_state;
    logic [ptss_pkg::TPS_W-1:0]       r_ticks_per_step;
    logic [ptss_pkg::TPS_W-1:0]       r_pre, n_pre;
    logic [ptss_pkg::SLOT_IW-1:0]     r_idx;
    logic [ptss_pkg::EMIT_W-1:0]      r_emit_cnt;
    logic                             r_pend_valid;
    logic [ptss_pkg::SLOT_W-1:0]      r_pend_slot;
    logic [ptss_pkg::TASK_W-1:0]      r_pend_task;
    logic                             r_out_valid;
    logic [ptss_pkg::SLOT_W-1:0]      r_out_slot;
    logic [ptss_pkg::TASK_W-1:0]      r_out_task;
    logic                             r_out_last;

    ptss_pkg::t_action                act;
    logic                             accept;
    logic                             step_go;
    logic                             scanning;
    logic                             flushing;
    logic                             scan_end;
    logic                             slot_ok;
    logic                             head_fire;
    logic                             take;
    logic                             out_load;
    ptss_pkg::t_slot_rec              ring [N];
    ptss_pkg::t_slot_rec              head_upd;

    assign act      = ptss_pkg::t_action'(i_action);
    assign accept   = start && !busy;
    assign slot_ok  = (32'(i_slot) < 32'(N));
    assign scan_end = (32'(r_idx) == 32'(N - 1));

    // prescaler next value and step start
    always_comb begin
        n_pre   = r_pre;
        step_go = 1'b0;
        if (accept && (act == ptss_pkg::ACT_TICK)) begin
            if ((r_pre + ptss_pkg::TPS_W'(1)) == r_ticks_per_step) begin
                n_pre   = '0;
                step_go = 1'b1;
            end else begin
                n_pre   = r_pre + ptss_pkg::TPS_W'(1);
            end
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptss_pkg::ST_IDLE:  if (step_go) n_state = ptss_pkg::ST_SCAN;
            ptss_pkg::ST_SCAN:  if (scan_end) n_state = ptss_pkg::ST_FLUSH;
            ptss_pkg::ST_FLUSH: n_state = ptss_pkg::ST_IDLE;
            default:            n_state = ptss_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        busy     = 1'b1;
        scanning = 1'b0;
        flushing = 1'b0;
        unique case (r_state)
            ptss_pkg::ST_IDLE:  busy     = 1'b0;
            ptss_pkg::ST_SCAN:  scanning = 1'b1;
            ptss_pkg::ST_FLUSH: flushing = 1'b1;
            default:            busy     = 1'b1;
        endcase
    end

    // ring of slot cells, rotating through the countdown unit at the head
    for (genvar k = 0; k < N; k++) begin : g_cell
        ptss_pkg::t_cell_cmd cmd;
        ptss_pkg::t_slot_rec rec_in;

        assign cmd.shift   = scanning;
        assign cmd.create  = accept && (act == ptss_pkg::ACT_CREATE) && slot_ok
                             && (32'(i_slot) == k);
        assign cmd.set_run = accept && (act == ptss_pkg::ACT_SET_RUN) && slot_ok
                             && (32'(i_slot) == k);
        assign cmd.del     = accept && (act == ptss_pkg::ACT_DELETE);
        assign rec_in      = (k == N - 1) ? head_upd : ring[(k + 1) % N];

        ptss_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (cmd),
            .i_rec_in      (rec_in),
            .i_task_id     (i_task_id),
            .i_first_delay (i_first_delay),
            .i_period      (i_period),
            .i_running     (i_running),
            .o_rec         (ring[k])
        );
    end

    ptss_update u_update (
        .i_rec  (ring[0]),
        .o_rec  (head_upd),
        .o_fire (head_fire)
    );

    // a fire is held one place so the final one of the step can carry last
    assign take     = scanning && head_fire
                      && (r_emit_cnt < ptss_pkg::EMIT_W'(ptss_pkg::MAX_RESULTS));
    assign out_load = (take || flushing) && r_pend_valid;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ptss_pkg::ST_IDLE;
            r_ticks_per_step <= ptss_pkg::TPS_RESET;
            r_pre            <= '0;
            r_idx            <= '0;
            r_emit_cnt       <= '0;
            r_pend_valid     <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pre       <= n_pre;
            r_out_valid <= out_load;
            if (i_cfg_we) begin
                r_ticks_per_step <= i_cfg_wdata;
            end
            if (scanning) begin
                r_idx <= r_idx + ptss_pkg::SLOT_IW'(1);
            end else begin
                r_idx <= '0;
            end
            if (step_go) begin
                r_emit_cnt <= '0;
            end else if (take) begin
                r_emit_cnt <= r_emit_cnt + ptss_pkg::EMIT_W'(1);
            end
            if (take) begin
                r_pend_valid <= 1'b1;
            end else if (flushing) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pend_slot <= ptss_pkg::SLOT_W'(r_idx);
            r_pend_task <= ring[0].task_id;
        end
        if (out_load) begin
            r_out_slot <= r_pend_slot;
            r_out_task <= r_pend_task;
            r_out_last <= flushing;
        end
    end

    assign o_fire_strobe = r_out_valid;
    assign o_fired_slot  = r_out_slot;
    assign o_fired_task  = r_out_task;
    assign o_last        = r_out_last;

    `include "periodic_task_slot_scheduler_macros.svh"

    // scan lasts exactly one pass over the ring
    `PTSS_ASSERT_NEXT(a_scan_len, i_clk, i_rst_n, scanning && scan_end, flushing)
    // no held result survives a step
    `PTSS_ASSERT_NOW(a_pend_idle, i_clk, i_rst_n, !busy, !r_pend_valid)
    // result count per step stays within limit
    `PTSS_ASSERT_NOW(a_emit_cap, i_clk, i_rst_n, 1'b1, r_emit_cnt <= 4'(ptss_pkg::MAX_RESULTS))
    // nothing follows the final result directly
    `PTSS_ASSERT_NEXT(a_last_gap, i_clk, i_rst_n, o_fire_strobe && o_last, !o_fire_strobe)

endmodule
